/* rtl/sacr_pkg.sv */
package sacr_pkg;

  localparam int SampleWidth = 16;
  localparam int GainWidth = 16;
  localparam int GainFracBits = 15;
  localparam int NumRegs = 8;
  localparam int NumLines = 7;
  localparam int RegIdxWidth = 3;
  localparam int LineIdxWidth = 3;
  // one memory holds all seven lines back to back
  localparam int MemDepth = 347 + 113 + 37 + 1601 + 1867 + 2053 + 2251;
  localparam int MemAddrWidth = $clog2(MemDepth);
  localparam int PosWidth = 12;

  // register indexes
  localparam logic [RegIdxWidth-1:0] RegPreGain = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_OUT
  } state_t;

  function automatic logic [PosWidth-1:0] line_len(input logic [LineIdxWidth-1:0] k);
    case (k)
      3'd0: line_len = 12'd347;
      3'd1: line_len = 12'd113;
      3'd2: line_len = 12'd37;
      3'd3: line_len = 12'd1601;
      3'd4: line_len = 12'd1867;
      3'd5: line_len = 12'd2053;
      default: line_len = 12'd2251;
    endcase
  endfunction

  function automatic logic [MemAddrWidth-1:0] line_base(input logic [LineIdxWidth-1:0] k);
    case (k)
      3'd0: line_base = MemAddrWidth'(0);
      3'd1: line_base = MemAddrWidth'(347);
      3'd2: line_base = MemAddrWidth'(460);
      3'd3: line_base = MemAddrWidth'(497);
      3'd4: line_base = MemAddrWidth'(2098);
      3'd5: line_base = MemAddrWidth'(3965);
      default: line_base = MemAddrWidth'(6018);
    endcase
  endfunction

  function automatic logic [GainWidth-1:0] reg_reset(input logic [RegIdxWidth-1:0] i);
    case (i)
      3'd0: reg_reset = 16'd3277;
      3'd1, 3'd2, 3'd3: reg_reset = 16'd22938;
      3'd4: reg_reset = 16'd26280;
      3'd5: reg_reset = 16'd25330;
      3'd6: reg_reset = 16'd24674;
      default: reg_reset = 16'd24019;
    endcase
  endfunction

endpackage

/* rtl/sacr_ram.sv */
module sacr_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sacr_mac.sv */
// one sample step: sat(a + sat(floor(d*g >> frac))), registered
module sacr_mac #(
  parameter int SampleWidth = 16,
  parameter int GainFracBits = 15
) (
  input  logic                          clk,
  input  logic signed [SampleWidth-1:0] d,
  input  logic signed [15:0]            g,
  input  logic signed [SampleWidth-1:0] a,
  output logic signed [SampleWidth-1:0] y
);
  localparam int ProdWidth = SampleWidth + 16;
  localparam int SumWidth = ProdWidth + 1;

  logic signed [ProdWidth-1:0] prod;
  logic signed [ProdWidth-1:0] shifted;
  logic signed [SumWidth-1:0]  sum;
  logic signed [SumWidth-1:0]  smax;
  logic signed [SumWidth-1:0]  smin;

  // arithmetic shift floors; saturating add of product and offset
  always_comb begin
    prod    = ProdWidth'(d) * ProdWidth'(g);
    shifted = prod >>> GainFracBits;
    smax    = SumWidth'({1'b0, {(SampleWidth-1){1'b1}}});
    smin    = -smax - SumWidth'(1);
    if (shifted > ProdWidth'(smax)) begin
      sum = smax + SumWidth'(a);
    end else if (shifted < ProdWidth'(smin)) begin
      sum = smin + SumWidth'(a);
    end else begin
      sum = SumWidth'(shifted) + SumWidth'(a);
    end
  end

  always_ff @(posedge clk) begin
    if (sum > smax) begin
      y <= smax[SampleWidth-1:0];
    end else if (sum < smin) begin
      y <= smin[SampleWidth-1:0];
    end else begin
      y <= sum[SampleWidth-1:0];
    end
  end
endmodule

/* rtl/schroeder_allpass_comb_reverb.sv */
// Schroeder reverberator: three allpass sections (347, 113, 37) then four
// parallel feedback combs (1601..2251), output is dry plus wet, saturated.
// All seven delay lines share one single-port-write RAM with a registered
// read. Each sample is handled in order: the beat is accepted; each allpass
// line takes a read, a wait and two multiply-add steps on a single shared
// multiplier; each comb line takes a read, a wait and one multiply-add; the
// result is handed over and held until taken. The pre-gain step overlaps
// the first read, and one beat is handled at a time. After reset a clearing
// pass zeroes the RAM; no sample is accepted during it.
module schroeder_allpass_comb_reverb
  import sacr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = sacr_pkg::SampleWidth,
  parameter int GAIN_FRAC_BITS = sacr_pkg::GainFracBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,  // dry_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,  // mixed_sample
  input  logic                                cfg_we,
  input  logic [sacr_pkg::RegIdxWidth-1:0]    cfg_index,
  input  logic [sacr_pkg::GainWidth-1:0]      cfg_data
);
  localparam int TW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int SW = SAMPLE_WIDTH;
  localparam logic signed [SW:0] WideMax = $signed({2'b00, {(SW-1){1'b1}}});
  localparam logic signed [SW:0] WideMin = $signed({2'b11, {(SW-1){1'b0}}});

  state_t state, state_next;
  logic [GainWidth-1:0] regs [NumRegs];
  logic [PosWidth-1:0] pos [NumLines];
  logic [MemAddrWidth-1:0] clr_addr;
  logic [LineIdxWidth-1:0] line;
  logic phase;    // 0 first mac, 1 second mac (allpass output)
  logic pre;      // pre-gain step pending
  logic signed [SW-1:0] dry, wet, sum, dval, vval;
  logic signed [SW-1:0] mac_d, mac_a, mac_y;
  logic signed [15:0] mac_g, g_cur, gf_cur;
  logic mac_busy;
  logic mem_we;
  logic [MemAddrWidth-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata, mem_rdata;
  logic signed [SW:0] sum_wide;
  logic signed [SW-1:0] sum_sat;
  logic signed [SW:0] mix_wide;
  logic signed [SW-1:0] mix_sat;

  sacr_ram #(.Width(SW), .Depth(MemDepth)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  sacr_mac #(.SampleWidth(SW), .GainFracBits(GAIN_FRAC_BITS)) u_mac (
    .clk(clk), .d(mac_d), .g(mac_g), .a(mac_a), .y(mac_y)
  );

  // gain selection and feedforward negation
  always_comb begin
    g_cur = $signed(regs[RegIdxWidth'(line) + RegIdxWidth'(1)]);
    gf_cur = (g_cur == -16'sd32768) ? 16'sd32767 : -g_cur;
  end

  // multiplier operands
  always_comb begin
    if (pre) begin
      mac_d = dry; mac_g = $signed(regs[RegPreGain]); mac_a = '0;
    end else if (phase) begin
      mac_d = vval; mac_g = gf_cur; mac_a = dval;
    end else begin
      mac_d = dval; mac_g = g_cur; mac_a = wet;
    end
  end

  // running saturated sum of comb outputs, and the final dry plus wet mix
  always_comb begin
    sum_wide = (SW+1)'(sum) + (SW+1)'(mac_y);
    if (sum_wide > WideMax) begin
      sum_sat = WideMax[SW-1:0];
    end else if (sum_wide < WideMin) begin
      sum_sat = WideMin[SW-1:0];
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
    mix_wide = (SW+1)'(dry) + (SW+1)'(sum_sat);
    if (mix_wide > WideMax) begin
      mix_sat = WideMax[SW-1:0];
    end else if (mix_wide < WideMin) begin
      mix_sat = WideMin[SW-1:0];
    end else begin
      mix_sat = mix_wide[SW-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == MemAddrWidth'(MemDepth - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_READ;
      ST_READ:  state_next = ST_WAIT;
      ST_WAIT:  state_next = ST_CALC;
      ST_CALC:  begin
        if (!mac_busy && !phase && line == LineIdxWidth'(NumLines - 1)) begin
          state_next = ST_OUT;
        end else if (!mac_busy && (phase || line > LineIdxWidth'(2))) begin
          state_next = ST_READ;
        end
      end
      ST_OUT:   if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    m_tvalid  = (state == ST_OUT);
    m_tdata   = TW'($unsigned(sum));
    mem_raddr = line_base(line) + MemAddrWidth'(pos[line]);
    mem_we    = (state == ST_CLEAR);
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == ST_CALC && !mac_busy && !phase) begin
      mem_we    = 1'b1;
      mem_waddr = mem_raddr;
      mem_wdata = mac_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      for (int i = 0; i < NumRegs; i++) regs[i] <= reg_reset(RegIdxWidth'(i));
      for (int i = 0; i < NumLines; i++) pos[i] <= '0;
      line <= '0;
      phase <= 1'b0;
      pre <= 1'b0;
      mac_busy <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) regs[cfg_index] <= cfg_data;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + MemAddrWidth'(1);
        ST_IDLE: if (s_tvalid) begin
          dry <= $signed(s_tdata[SW-1:0]);
          line <= '0;
          phase <= 1'b0;
          pre <= 1'b1;
          sum <= '0;
        end
        ST_READ: ;
        ST_WAIT: begin
          dval <= $signed(mem_rdata);
          mac_busy <= 1'b1;
          // pre-gain result lands in wet before the first line uses it
          if (pre) begin
            wet <= mac_y;
            pre <= 1'b0;
          end
        end
        ST_CALC: begin
          if (mac_busy) begin
            // wait for the registered mac result
            mac_busy <= 1'b0;
          end else if (!phase) begin
            // line write done this cycle; advance position
            pos[line] <= (pos[line] == line_len(line) - PosWidth'(1)) ? '0
                         : pos[line] + PosWidth'(1);
            if (line > LineIdxWidth'(2)) begin
              // last comb also adds the dry sample
              if (line == LineIdxWidth'(NumLines - 1)) begin
                sum <= mix_sat;
              end else begin
                sum <= sum_sat;
              end
              line <= line + LineIdxWidth'(1);
            end else begin
              vval <= mac_y;
              phase <= 1'b1;
              mac_busy <= 1'b1;
            end
          end else begin
            wet <= mac_y;
            phase <= 1'b0;
            line <= line + LineIdxWidth'(1);
          end
        end
        ST_OUT: if (m_tready) line <= '0;
        default: ;
      endcase
    end
  end
endmodule

/* rtl/sacr_checker.sv */
module sacr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  // no beat taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while output pending");
  // a result follows only an accepted beat
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !s_tready) else $error("spurious result");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
endmodule

bind schroeder_allpass_comb_reverb sacr_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
